// ----- rtl/rlse_pkg.sv -----
// Shared types and constants for the RGB LED strip serial encoder.
package rlse_pkg;

    // Word kinds on the input stream.
    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_UPDATE = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } opcode_e;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_LED_COUNT = 2'd0,
        CFG_INVERT    = 2'd1,
        CFG_AUTO      = 2'd2,
        CFG_UNUSED    = 2'd3
    } cfg_index_e;

    localparam int COLOUR_W      = 24;
    localparam int BYTES_PER_LED = 12;
    localparam int LED_COUNT_W   = 7;

    localparam logic [LED_COUNT_W-1:0] LED_COUNT_RESET = 7'd60;

    // Line codes for one data bit, four line bits each.
    localparam logic [3:0] CODE_ONE  = 4'hE;
    localparam logic [3:0] CODE_ZERO = 4'h8;

    // Byte slot of the last byte of one LED.
    localparam logic [3:0] LAST_SLOT = 4'd11;

    // Per-tick information carried from the accept stage to the encode stage.
    typedef struct packed {
        logic [3:0] slot;
        logic       in_colour;
        logic       byte_valid;
        logic       last;
        logic       invert;
    } tick_info_t;

endpackage

// ----- rtl/rlse_led_store.sv -----
// Colour store: one 24-bit colour per LED in a synchronous RAM with per-entry valid bits.
module rlse_led_store #(
    parameter int MAX_LEDS = 64,
    localparam int ADDR_W  = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic [rlse_pkg::COLOUR_W-1:0] wr_data,
    input  logic                          rd_en,
    input  logic [ADDR_W-1:0]             rd_addr,
    output logic [rlse_pkg::COLOUR_W-1:0] rd_data
);

    logic [rlse_pkg::COLOUR_W-1:0] mem [MAX_LEDS];
    logic [MAX_LEDS-1:0]           valid_reg;
    logic [rlse_pkg::COLOUR_W-1:0] rd_data_reg;
    logic                          rd_valid_reg;

    // RAM array: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Valid bits make never-written entries read as zero after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ----- rtl/rgb_led_strip_serial_encoder.sv -----
// Top level of the RGB LED strip serial encoder: frame sequencing and byte encoding.
//
//  Channel   Direction  Handshake                      Word
//  s_axis    in         s_axis_tvalid / s_axis_tready  opcode, led_index, red, green, blue
//  m_axis    out        m_axis_tvalid / m_axis_tready  line_byte; tuser byte_valid; tlast
//  cfg       in         cfg_we (no wait)               led_count, invert_output, auto_refresh
//
// One input word per cycle is taken when the output side keeps up; a tick word reaches
// m_axis through the registered colour RAM read and then the output register.
// The registered RAM read sets the pipeline depth, not the rate.
// Reset clears all control state and the colour valid bits at once, so there is no
// clearing pass. A stalled output holds the encode stage, which then holds s_axis_tready low.
module rgb_led_strip_serial_encoder #(
    parameter int MAX_LEDS    = 64,
    parameter int RESET_BYTES = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // opcode[1:0], led_index[7:2], red[15:8],
                                        // green[23:16], blue[31:24]
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // line_byte[7:0]
    output logic        m_axis_tuser,   // byte_valid[0]
    output logic        m_axis_tlast,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [6:0]  cfg_wdata
);

    localparam int ADDR_W  = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int NUM_W   = ($clog2(MAX_LEDS + 1) > rlse_pkg::LED_COUNT_W) ?
                             $clog2(MAX_LEDS + 1) : rlse_pkg::LED_COUNT_W;
    localparam int POS_W   = $clog2(MAX_LEDS * rlse_pkg::BYTES_PER_LED + RESET_BYTES + 1);
    localparam int LED_W   = POS_W - 3;

    // Configuration registers
    logic [rlse_pkg::LED_COUNT_W-1:0] led_count_reg;
    logic                             invert_reg;
    logic                             auto_reg;

    // Frame sequencing state
    logic             sending_reg,  sending_next;
    logic             pending_reg,  pending_next;
    logic [POS_W-1:0] pos_reg,      pos_next;
    logic [LED_W-1:0] led_reg,      led_next;
    logic [3:0]       slot_reg,     slot_next;

    // Pipeline registers
    logic                 s1_valid_reg;
    rlse_pkg::tick_info_t s1_info_reg;
    rlse_pkg::tick_info_t info_next;
    logic                 out_valid_reg;
    logic [7:0]           out_byte_reg;
    logic                 out_user_reg;
    logic                 out_last_reg;

    // Input word fields
    rlse_pkg::opcode_e                opcode;
    logic [5:0]                       led_index;
    logic [7:0]                       red;
    logic [7:0]                       green;
    logic [7:0]                       blue;

    logic                             accept;
    logic                             s1_move;
    logic                             tick_fire;
    logic                             col_we;
    logic [rlse_pkg::COLOUR_W-1:0]    rd_colour;

    logic [NUM_W-1:0] active_leds;
    logic [POS_W-1:0] colour_len;
    logic [POS_W-1:0] frame_len;
    logic             eff_sending;
    logic [POS_W-1:0] cur_pos;
    logic [LED_W-1:0] cur_led;
    logic [3:0]       cur_slot;
    logic [POS_W-1:0] pos_plus1;
    logic             is_last;

    logic [7:0]       chan;
    logic [1:0]       pair;
    logic [7:0]       enc_byte;

    assign opcode    = rlse_pkg::opcode_e'(s_axis_tdata[1:0]);
    assign led_index = s_axis_tdata[7:2];
    assign red       = s_axis_tdata[15:8];
    assign green     = s_axis_tdata[23:16];
    assign blue      = s_axis_tdata[31:24];

    // Handshake: the encode stage frees up when the output register can take its word.
    assign s1_move       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_move;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg <= rlse_pkg::LED_COUNT_RESET;
            invert_reg    <= 1'b1;
            auto_reg      <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (rlse_pkg::cfg_index_e'(cfg_addr))
                rlse_pkg::CFG_LED_COUNT: led_count_reg <= cfg_wdata;
                rlse_pkg::CFG_INVERT:    invert_reg    <= cfg_wdata[0];
                rlse_pkg::CFG_AUTO:      auto_reg      <= cfg_wdata[0];
                default:                 ;
            endcase
        end
    end

    // Frame geometry: LED count saturated, twelve bytes per LED, then the reset bytes.
    assign active_leds = (NUM_W'(led_count_reg) > NUM_W'(MAX_LEDS)) ?
                         NUM_W'(MAX_LEDS) : NUM_W'(led_count_reg);
    assign colour_len  = (POS_W'(active_leds) << 3) + (POS_W'(active_leds) << 2);
    assign frame_len   = colour_len + POS_W'(RESET_BYTES);

    // Position of the byte a tick sends; an idle start begins at zero.
    assign eff_sending = sending_reg || auto_reg;
    assign cur_pos     = sending_reg ? pos_reg  : '0;
    assign cur_led     = sending_reg ? led_reg  : '0;
    assign cur_slot    = sending_reg ? slot_reg : '0;
    assign pos_plus1   = cur_pos + POS_W'(1);
    assign is_last     = (pos_plus1 >= frame_len);

    // Next-state logic for frame sequencing.
    always_comb
    begin
        sending_next = sending_reg;
        pending_next = pending_reg;
        pos_next     = pos_reg;
        led_next     = led_reg;
        slot_next    = slot_reg;
        if (accept)
        begin
            case (opcode)
                rlse_pkg::OP_UPDATE:
                begin
                    if (!auto_reg)
                    begin
                        if (sending_reg)
                        begin
                            pending_next = 1'b1;
                        end
                        else
                        begin
                            sending_next = 1'b1;
                            pos_next     = '0;
                            led_next     = '0;
                            slot_next    = '0;
                        end
                    end
                end
                rlse_pkg::OP_TICK:
                begin
                    if (eff_sending)
                    begin
                        if (is_last)
                        begin
                            pos_next  = '0;
                            led_next  = '0;
                            slot_next = '0;
                            if (auto_reg || pending_reg)
                            begin
                                pending_next = 1'b0;
                                sending_next = 1'b1;
                            end
                            else
                            begin
                                sending_next = 1'b0;
                            end
                        end
                        else
                        begin
                            sending_next = 1'b1;
                            pos_next     = pos_plus1;
                            if (cur_slot == rlse_pkg::LAST_SLOT)
                            begin
                                slot_next = '0;
                                led_next  = cur_led + LED_W'(1);
                            end
                            else
                            begin
                                slot_next = cur_slot + 4'd1;
                                led_next  = cur_led;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Outputs of the accept stage: RAM access and tick information.
    always_comb
    begin
        tick_fire            = accept && (opcode == rlse_pkg::OP_TICK);
        col_we               = accept && (opcode == rlse_pkg::OP_WRITE) &&
                               (32'(led_index) < 32'(MAX_LEDS));
        info_next.slot       = cur_slot;
        info_next.in_colour  = eff_sending && (cur_pos < colour_len);
        info_next.byte_valid = eff_sending;
        info_next.last       = eff_sending && is_last;
        info_next.invert     = invert_reg;
    end

    // Sequencing state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sending_reg <= 1'b0;
            pending_reg <= 1'b0;
            pos_reg     <= '0;
            led_reg     <= '0;
            slot_reg    <= '0;
        end
        else
        begin
            sending_reg <= sending_next;
            pending_reg <= pending_next;
            pos_reg     <= pos_next;
            led_reg     <= led_next;
            slot_reg    <= slot_next;
        end
    end

    // Colour RAM; a write lands before any later tick reads it.
    rlse_led_store #(
        .MAX_LEDS (MAX_LEDS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (col_we),
        .wr_addr (ADDR_W'(led_index)),
        .wr_data ({green, red, blue}),
        .rd_en   (tick_fire),
        .rd_addr (ADDR_W'(cur_led)),
        .rd_data (rd_colour)
    );

    // Encode stage: pick the channel and bit pair, then map each bit to its line code.
    always_comb
    begin
        case (s1_info_reg.slot[3:2])
            2'd0:    chan = rd_colour[23:16];
            2'd1:    chan = rd_colour[15:8];
            default: chan = rd_colour[7:0];
        endcase
        case (s1_info_reg.slot[1:0])
            2'd0:    pair = chan[7:6];
            2'd1:    pair = chan[5:4];
            2'd2:    pair = chan[3:2];
            default: pair = chan[1:0];
        endcase
        if (s1_info_reg.in_colour)
        begin
            enc_byte = {pair[1] ? rlse_pkg::CODE_ONE : rlse_pkg::CODE_ZERO,
                        pair[0] ? rlse_pkg::CODE_ONE : rlse_pkg::CODE_ZERO};
        end
        else
        begin
            enc_byte = 8'h00;
        end
        enc_byte = enc_byte ^ {8{s1_info_reg.invert}};
    end

    // Pipeline valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tick_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            s1_info_reg <= info_next;
        end
        if (s1_move)
        begin
            out_byte_reg <= enc_byte;
            out_user_reg <= s1_info_reg.byte_valid;
            out_last_reg <= s1_info_reg.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ----- tb/sv/rgb_led_strip_serial_encoder_tb.sv -----
// Self-checking testbench for the RGB LED strip serial encoder stream interface.
`timescale 1ns / 1ps

module rgb_led_strip_serial_encoder_tb;

    localparam int MAX_LEDS    = 64;
    localparam int RESET_BYTES = 20;
    localparam int DRAIN_PAD   = 6;

    // One output word as the checker sees it.
    typedef struct packed {
        logic [7:0] line_byte;
        logic       byte_valid;
        logic       frame_last;
    } line_word_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [7:0]           m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 cfg_we;
    rlse_pkg::cfg_index_e cfg_addr;
    logic [6:0]           cfg_wdata;

    // Encoder state as the testbench tracks it.
    logic [23:0] led_colours [MAX_LEDS];
    bit          frame_active;
    bit          refresh_pending;
    int unsigned byte_pos;
    logic [6:0]  led_count_reg;
    bit          invert_on;
    bit          auto_on;

    logic [31:0] pending_words [$];
    line_word_t  expected_line [$];
    int          words_queued;
    int          accepted_words;
    int          items_pushed;
    int          error_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          word_taken;
    bit          hold_go;
    bit          rx_hold;

    rgb_led_strip_serial_encoder #(
        .MAX_LEDS    (MAX_LEDS),
        .RESET_BYTES (RESET_BYTES)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    task automatic report_mismatch(input string what);
        error_count++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // Apply one accepted input word to the tracked state and queue any output word.
    task automatic encode_word(input logic [31:0] w);
        rlse_pkg::opcode_e op;
        logic [7:0]  inv;
        logic [7:0]  line_b;
        logic [23:0] colour;
        logic [7:0]  chan;
        logic [1:0]  pair;
        int unsigned active;
        int unsigned colour_len;
        int unsigned frame_len;
        int unsigned slot;
        bit          last_b;
        op  = rlse_pkg::opcode_e'(w[1:0]);
        inv = invert_on ? 8'hFF : 8'h00;
        case (op)
            rlse_pkg::OP_WRITE:
            begin
                // Stored as green, red, blue from the top down.
                led_colours[w[7:2]] = {w[23:16], w[15:8], w[31:24]};
            end
            rlse_pkg::OP_UPDATE:
            begin
                if (!auto_on)
                begin
                    if (frame_active)
                    begin
                        refresh_pending = 1'b1;
                    end
                    else
                    begin
                        frame_active = 1'b1;
                        byte_pos     = 0;
                    end
                end
            end
            rlse_pkg::OP_TICK:
            begin
                if (!frame_active && auto_on)
                begin
                    frame_active = 1'b1;
                    byte_pos     = 0;
                end
                if (!frame_active)
                begin
                    expected_line.push_back('{inv, 1'b0, 1'b0});
                end
                else
                begin
                    active     = (led_count_reg > MAX_LEDS) ? MAX_LEDS : led_count_reg;
                    colour_len = active * rlse_pkg::BYTES_PER_LED;
                    frame_len  = colour_len + RESET_BYTES;
                    line_b     = 8'h00;
                    if (byte_pos < colour_len)
                    begin
                        // Two data bits per byte, each widened to a four-bit line code.
                        colour = led_colours[byte_pos / rlse_pkg::BYTES_PER_LED];
                        slot   = byte_pos % rlse_pkg::BYTES_PER_LED;
                        chan   = colour[8 * (2 - slot / 4) +: 8];
                        pair   = chan[6 - 2 * (slot % 4) +: 2];
                        line_b = {pair[1] ? rlse_pkg::CODE_ONE : rlse_pkg::CODE_ZERO,
                                  pair[0] ? rlse_pkg::CODE_ONE : rlse_pkg::CODE_ZERO};
                    end
                    last_b = (byte_pos + 1) >= frame_len;
                    expected_line.push_back('{line_b ^ inv, 1'b1, last_b});
                    if (last_b)
                    begin
                        byte_pos = 0;
                        if (auto_on || refresh_pending)
                        begin
                            refresh_pending = 1'b0;
                        end
                        else
                        begin
                            frame_active = 1'b0;
                        end
                    end
                    else
                    begin
                        byte_pos++;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Compare one output word with the oldest expected word.
    task automatic check_line_word();
        line_word_t want;
        if (expected_line.size() == 0)
        begin
            report_mismatch($sformatf("output word 0x%02h with nothing expected", m_axis_tdata));
            return;
        end
        want = expected_line.pop_front();
        if (m_axis_tdata !== want.line_byte)
        begin
            report_mismatch($sformatf("line_byte 0x%02h, expected 0x%02h",
                                      m_axis_tdata, want.line_byte));
        end
        if (m_axis_tuser !== want.byte_valid)
        begin
            report_mismatch($sformatf("byte_valid %b, expected %b",
                                      m_axis_tuser, want.byte_valid));
        end
        if (m_axis_tlast !== want.frame_last)
        begin
            report_mismatch($sformatf("frame_last %b, expected %b",
                                      m_axis_tlast, want.frame_last));
        end
    endtask

    // Monitor: take note of accepted input words and check output words.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                encode_word(s_axis_tdata);
                accepted_words++;
                word_taken = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_line_word();
            end
        end
    end

    // Driver: present the next pending word, with random gaps between words.
    always @(negedge clk)
    begin
        if (word_taken || !s_axis_tvalid)
        begin
            if (rst_n && pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tdata  <= pending_words.pop_front();
                s_axis_tvalid <= 1'b1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
        word_taken = 1'b0;
    end

    // Receiver: random back-pressure, or a full hold during the long stall.
    always @(negedge clk)
    begin
        m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Long receiver stall while the sender keeps offering ticks.
    initial
    begin
        rx_hold = 1'b0;
        wait (hold_go);
        repeat (40) @(posedge clk);
        rx_hold = 1'b1;
        repeat (400) @(posedge clk);
        rx_hold = 1'b0;
    end

    // Overall time limit.
    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic push_word(input rlse_pkg::opcode_e op, input logic [29:0] rest);
        pending_words.push_back({rest, op});
        words_queued++;
        if (op != rlse_pkg::OP_NONE)
        begin
            items_pushed++;
        end
    endtask

    task automatic push_write(input logic [5:0] idx);
        push_word(rlse_pkg::OP_WRITE, {8'($urandom), 8'($urandom), 8'($urandom), idx});
    endtask

    task automatic push_ticks(input int n);
        repeat (n) push_word(rlse_pkg::OP_TICK, 30'($urandom));
    endtask

    // One random word of any kind, reserved opcode included.
    task automatic push_noise();
        int roll;
        roll = $urandom_range(9);
        if (roll < 4)
        begin
            push_ticks(1);
        end
        else if (roll < 7)
        begin
            push_write(6'($urandom));
        end
        else if (roll < 9)
        begin
            push_word(rlse_pkg::OP_UPDATE, 30'($urandom));
        end
        else
        begin
            push_word(rlse_pkg::OP_NONE, 30'($urandom));
        end
    endtask

    // Wait until every queued word is taken and every output word has come.
    task automatic drain();
        do @(negedge clk);
        while (accepted_words != words_queued || expected_line.size() != 0);
        repeat (DRAIN_PAD) @(negedge clk);
    endtask

    task automatic set_reg(input rlse_pkg::cfg_index_e idx, input logic [6:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        case (idx)
            rlse_pkg::CFG_LED_COUNT: led_count_reg = value;
            rlse_pkg::CFG_INVERT:    invert_on     = value[0];
            rlse_pkg::CFG_AUTO:      auto_on       = value[0];
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // More gaps on the receiver first, then more on the sender, then none at all.
    task automatic pick_idle_mode();
        if (items_pushed < 550)
        begin
            send_idle_pct = 34;
            recv_idle_pct = 72;
        end
        else if (items_pushed < 1100)
        begin
            send_idle_pct = 72;
            recv_idle_pct = 34;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    // New random settings, then mostly whole frames with random colours.
    task automatic random_phase();
        int          roll;
        int unsigned active;
        int          frame_ticks;
        logic [6:0]  count_val;
        drain();
        pick_idle_mode();
        roll = $urandom_range(11);
        if (roll == 0)
        begin
            count_val = 7'd0;
        end
        else if (roll == 1)
        begin
            count_val = 7'd64;
        end
        else if (roll == 2)
        begin
            count_val = 7'($urandom_range(65, 127));
        end
        else if (roll == 3)
        begin
            count_val = 7'($urandom_range(6, 63));
        end
        else
        begin
            count_val = 7'($urandom_range(1, 5));
        end
        if ($urandom_range(3) != 0)
        begin
            set_reg(rlse_pkg::CFG_LED_COUNT, count_val);
        end
        if ($urandom_range(2) != 0)
        begin
            set_reg(rlse_pkg::CFG_INVERT, 7'($urandom));
        end
        if ($urandom_range(2) != 0)
        begin
            set_reg(rlse_pkg::CFG_AUTO, {6'($urandom), ($urandom_range(3) == 0)});
        end
        if ($urandom_range(15) == 0)
        begin
            set_reg(rlse_pkg::CFG_UNUSED, 7'($urandom));
        end
        active = (led_count_reg > MAX_LEDS) ? MAX_LEDS : led_count_reg;
        if ($urandom_range(4) != 0)
        begin
            repeat ($urandom_range(1, 4))
            begin
                push_write(6'((active == 0) ? $urandom_range(63) : $urandom_range(active - 1)));
            end
            push_word(rlse_pkg::OP_UPDATE, 30'($urandom));
            frame_ticks = active * rlse_pkg::BYTES_PER_LED + RESET_BYTES + $urandom_range(3);
            if (frame_ticks > 120)
            begin
                frame_ticks = $urandom_range(30, 120);
            end
            repeat (frame_ticks)
            begin
                push_ticks(1);
                if ($urandom_range(15) == 0)
                begin
                    push_noise();
                end
            end
        end
        else
        begin
            repeat ($urandom_range(10, 40)) push_noise();
        end
    endtask

    // Stimulus and end of run.
    initial
    begin
        bit hold_done;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = rlse_pkg::CFG_LED_COUNT;
        cfg_wdata     = '0;
        hold_go       = 1'b0;
        hold_done     = 1'b0;
        word_taken    = 1'b0;
        words_queued   = 0;
        accepted_words = 0;
        items_pushed   = 0;
        error_count    = 0;
        for (int i = 0; i < MAX_LEDS; i++)
        begin
            led_colours[i] = '0;
        end
        frame_active    = 1'b0;
        refresh_pending = 1'b0;
        byte_pos        = 0;
        led_count_reg   = rlse_pkg::LED_COUNT_RESET;
        invert_on       = 1'b1;
        auto_on         = 1'b0;
        pick_idle_mode();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: idle ticks at the inverted level, colour writes, reserved opcode.
        push_ticks(1);
        push_word(rlse_pkg::OP_WRITE, {8'hFF, 8'h00, 8'hFF, 6'd0});
        push_word(rlse_pkg::OP_WRITE, {8'h00, 8'hFF, 8'h00, 6'd63});
        push_word(rlse_pkg::OP_WRITE, {8'h0F, 8'h55, 8'hAA, 6'd1});
        push_word(rlse_pkg::OP_NONE, '1);
        push_word(rlse_pkg::OP_NONE, '0);
        push_ticks(1);

        // One LED, no inversion: a request while sending is held and runs next.
        drain();
        set_reg(rlse_pkg::CFG_LED_COUNT, 7'd1);
        set_reg(rlse_pkg::CFG_INVERT, 7'd0);
        set_reg(rlse_pkg::CFG_AUTO, 7'd0);
        set_reg(rlse_pkg::CFG_UNUSED, 7'h7F);
        push_ticks(1);
        push_word(rlse_pkg::OP_UPDATE, '0);
        push_word(rlse_pkg::OP_UPDATE, '1);
        push_ticks(2);
        push_word(rlse_pkg::OP_WRITE, {8'hC3, 8'h3C, 8'h81, 6'd0});
        push_ticks(63);

        // No LEDs with auto refresh: frames of reset bytes only, requests ignored.
        drain();
        set_reg(rlse_pkg::CFG_LED_COUNT, 7'd0);
        set_reg(rlse_pkg::CFG_INVERT, 7'h7F);
        set_reg(rlse_pkg::CFG_AUTO, 7'h7F);
        push_ticks(45);
        push_word(rlse_pkg::OP_UPDATE, 30'($urandom));
        push_ticks(3);

        // Count above the maximum saturates; then shrink it under the current position.
        drain();
        set_reg(rlse_pkg::CFG_LED_COUNT, 7'd127);
        set_reg(rlse_pkg::CFG_AUTO, 7'd0);
        set_reg(rlse_pkg::CFG_INVERT, 7'd0);
        push_word(rlse_pkg::OP_UPDATE, 30'($urandom));
        push_ticks(40);
        drain();
        set_reg(rlse_pkg::CFG_LED_COUNT, 7'd2);
        push_ticks(5);
        drain();
        set_reg(rlse_pkg::CFG_LED_COUNT, 7'd1);
        push_ticks(3);

        // Random phases, with one full frame of every LED under a long receiver stall.
        while (items_pushed < 1950)
        begin
            if (items_pushed >= 1100 && !hold_done)
            begin
                drain();
                pick_idle_mode();
                set_reg(rlse_pkg::CFG_LED_COUNT, 7'd64);
                set_reg(rlse_pkg::CFG_AUTO, 7'd0);
                repeat (8) push_write(6'($urandom));
                push_word(rlse_pkg::OP_UPDATE, 30'($urandom));
                push_ticks(rlse_pkg::BYTES_PER_LED * MAX_LEDS + RESET_BYTES + 2);
                hold_go   = 1'b1;
                hold_done = 1'b1;
            end
            else
            begin
                random_phase();
            end
        end

        drain();
        if (error_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/rlse_pkg.sv
rtl/rlse_led_store.sv
rtl/rgb_led_strip_serial_encoder.sv
tb/sv/rgb_led_strip_serial_encoder_tb.sv
